>>> design/mad_pkg.sv
package mad_pkg;

    // Default widths of the sample and timestamp arithmetic.
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int TIME_BITS_DEF   = 32;

    // Fixed field widths of the stream words.
    localparam int TIME_FIELD_W = 32;
    localparam int OUT_FIELD_W  = 16;
    localparam int OUT_TDATA_W  = ((2 + 2 * OUT_FIELD_W + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] CFG_MOTION_THRESHOLD = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_TIME_MS     = 1'b1;

    localparam logic [CFG_W-1:0] MOTION_THRESHOLD_RST = 16'd205;
    localparam logic [CFG_W-1:0] HOLD_TIME_MS_RST     = 16'd2000;

    // Squaring phase: three products, the last one added in the cycle after it is formed.
    localparam int SQUARE_CYCLES = 4;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_DECIDE
    } t_state;

    // Controls from the sequencer to the datapath and decision logic.
    typedef struct packed {
        logic       load;
        logic       square;
        logic [1:0] axis;
        logic       accum;
        logic       root_step;
        logic       commit;
    } t_dp_ctrl;

    typedef struct packed {
        logic                   alert;
        logic                   moving;
        logic [OUT_FIELD_W-1:0] magnitude;
        logic [OUT_FIELD_W-1:0] change;
    } t_result;

endpackage

>>> design/mad_ctrl.sv
module mad_ctrl
    import mad_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_free,
    output logic     o_in_ready,
    output t_dp_ctrl o_ctrl
);

    localparam int CNT_W = $clog2(SAMPLE_BITS + 1);
    localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(SQUARE_CYCLES - 1);
    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(SAMPLE_BITS - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and step counter.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + CNT_W'(1);
        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    n_state = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (r_cnt == SQ_LAST) begin
                    n_state = ST_ROOT;
                    n_cnt   = '0;
                end
            end
            ST_ROOT: begin
                if (r_cnt == ROOT_LAST) begin
                    n_state = ST_DECIDE;
                    n_cnt   = '0;
                end
            end
            ST_DECIDE: begin
                n_cnt = '0;
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_ready = 1'b0;
        o_ctrl     = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_ctrl.load = i_in_valid;
            end
            ST_SQUARE: begin
                o_ctrl.square = (r_cnt != SQ_LAST);
                o_ctrl.axis   = r_cnt[1:0];
                o_ctrl.accum  = (r_cnt != '0);
            end
            ST_ROOT: begin
                o_ctrl.root_step = 1'b1;
            end
            ST_DECIDE: begin
                o_ctrl.commit = i_out_free;
            end
            default: begin
                o_ctrl = '0;
            end
        endcase
    end

endmodule

>>> design/mad_datapath.sv
module mad_datapath
    import mad_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic                    i_clk,
    input  t_dp_ctrl                i_ctrl,
    input  logic [SAMPLE_BITS-1:0]  i_accel_x,
    input  logic [SAMPLE_BITS-1:0]  i_accel_y,
    input  logic [SAMPLE_BITS-1:0]  i_accel_z,
    input  logic [TIME_FIELD_W-1:0] i_time_ms,
    output logic [SAMPLE_BITS-1:0]  o_magnitude,
    output logic [TIME_BITS-1:0]    o_now
);

    localparam int S  = SAMPLE_BITS;
    localparam int SQ = 2 * SAMPLE_BITS;

    logic [S-1:0]         r_x, r_y, r_z;
    logic [TIME_BITS-1:0] r_now;
    logic [SQ-1:0]        r_prod;
    logic [SQ-1:0]        r_acc;
    logic [S-1:0]         r_rem;
    logic [S-1:0]         r_root;

    logic [S-1:0]  sel;
    logic [S-1:0]  abs_sel;
    logic [SQ-1:0] square;
    logic [S+1:0]  rem_sh;
    logic [S+1:0]  trial;
    logic [S+2:0]  diff;
    logic          ge;

    always_comb begin
        case (i_ctrl.axis)
            AXIS_X:  sel = r_x;
            AXIS_Y:  sel = r_y;
            AXIS_Z:  sel = r_z;
            default: sel = '0;
        endcase
    end

    // Most negative sample maps to 2^(S-1), which still fits unsigned.
    assign abs_sel = sel[S-1] ? (~sel + S'(1)) : sel;
    assign square  = abs_sel * abs_sel;

    // One root digit per cycle: bring down two radicand bits and try to
    // subtract 4*root+1 from the partial remainder.
    assign rem_sh = {r_rem, r_acc[SQ-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign diff   = {1'b0, rem_sh} - {1'b0, trial};
    assign ge     = ~diff[S+2];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_x    <= i_accel_x;
            r_y    <= i_accel_y;
            r_z    <= i_accel_z;
            r_now  <= TIME_BITS'(i_time_ms);
            r_acc  <= '0;
            r_rem  <= '0;
            r_root <= '0;
        end else begin
            if (i_ctrl.square) begin
                r_prod <= square;
            end
            if (i_ctrl.accum) begin
                r_acc <= r_acc + r_prod;
            end
            if (i_ctrl.root_step) begin
                r_acc  <= r_acc << 2;
                r_rem  <= ge ? diff[S-1:0] : rem_sh[S-1:0];
                r_root <= {r_root[S-2:0], ge};
            end
        end
    end

    assign o_magnitude = r_root;
    assign o_now       = r_now;

endmodule

>>> design/mad_decide.sv
module mad_decide
    import mad_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_commit,
    input  logic [SAMPLE_BITS-1:0] i_magnitude,
    input  logic [TIME_BITS-1:0]   i_now,
    input  logic [CFG_W-1:0]       i_threshold,
    input  logic [CFG_W-1:0]       i_hold_ms,
    output t_result                o_result
);

    localparam int CMP_W = SAMPLE_BITS + CFG_W;

    logic [SAMPLE_BITS-1:0] r_prev_mag;
    logic                   r_alert;
    logic [TIME_BITS-1:0]   r_mov_since, r_still_since;
    logic                   r_mov_valid, r_still_valid;

    logic [SAMPLE_BITS-1:0] chg;
    logic                   moving;
    logic [TIME_BITS-1:0]   n_mov_since, n_still_since;
    logic                   n_mov_valid, n_still_valid;
    logic [TIME_BITS-1:0]   sel_since;
    logic                   sel_valid;
    logic [TIME_BITS-1:0]   elapsed;
    logic                   n_alert;

    assign chg = (i_magnitude >= r_prev_mag) ? (i_magnitude - r_prev_mag)
                                              : (r_prev_mag - i_magnitude);
    assign moving = CMP_W'(chg) > CMP_W'(i_threshold);

    // A timer starts on the first sample of its kind and is dropped by the
    // first sample of the other kind.
    assign n_mov_since   = (moving && !r_mov_valid) ? i_now : r_mov_since;
    assign n_mov_valid   = moving;
    assign n_still_since = (!moving && !r_still_valid) ? i_now : r_still_since;
    assign n_still_valid = !moving;

    // Calm watches the movement timer, alert watches the still timer.
    assign sel_since = r_alert ? n_still_since : n_mov_since;
    assign sel_valid = r_alert ? n_still_valid : n_mov_valid;
    assign elapsed   = i_now - sel_since;
    assign n_alert   = (sel_valid && (elapsed > TIME_BITS'(i_hold_ms))) ? !r_alert : r_alert;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_mag    <= '0;
            r_alert       <= 1'b0;
            r_mov_since   <= '0;
            r_mov_valid   <= 1'b0;
            r_still_since <= '0;
            r_still_valid <= 1'b0;
        end else if (i_commit) begin
            r_prev_mag    <= i_magnitude;
            r_alert       <= n_alert;
            r_mov_since   <= n_mov_since;
            r_mov_valid   <= n_mov_valid;
            r_still_since <= n_still_since;
            r_still_valid <= n_still_valid;
        end
    end

    always_comb begin
        o_result.alert     = n_alert;
        o_result.moving    = moving;
        o_result.magnitude = OUT_FIELD_W'(i_magnitude);
        o_result.change    = OUT_FIELD_W'(chg);
    end

endmodule

>>> design/motion_alert_detector.sv
// Time-qualified motion detector.
// Input stream (s_axis): one word per accelerometer sample, carrying the three
// signed axes and a free-running millisecond timestamp. Output stream (m_axis):
// one word per sample with the alert state, the moving flag, the floor square
// root of the summed squared axes and its absolute change from the last sample.
// The configuration port writes the motion threshold and the hold time; it is
// meant to be written only while no sample is in flight.
// A result word is offered once its sample word has passed the squaring, the
// square root and the decision step; a new word is taken only in the idle
// state, in which the block is ready again, so one sample is in flight at a
// time. The squaring uses one shared squarer (three products and a final sum),
// and the square root resolves one root bit per cycle through one shared
// subtract-and-compare unit before the decision logic.
// Once a result sits in the output register the block returns to idle and may
// accept the next word; if the receiver stalls, the following result waits in
// the decision step until the output register is free, so nothing is lost.
// Reset (synchronous, active low) empties the output, returns the block to
// calm with both timers stopped and the previous magnitude at zero, and
// reloads the threshold (205) and hold time (2000 ms) defaults.
module motion_alert_detector
    import mad_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Sample words.
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // accel_x, accel_y, accel_z (SAMPLE_BITS each), time_ms (32), zero padding.
    input  logic [((3*SAMPLE_BITS+TIME_FIELD_W+7)/8)*8-1:0] i_s_axis_tdata,
    // Result words.
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    // alert (1), moving (1), magnitude (16), change (16), zero padding.
    output logic [OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // Configuration writes.
    input  logic                    i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [CFG_W-1:0]        i_cfg_wdata
);

    localparam int S = SAMPLE_BITS;

    t_dp_ctrl             dp_ctrl;
    logic                 out_free;
    logic [S-1:0]         magnitude;
    logic [TIME_BITS-1:0] now;
    t_result              result;

    logic [CFG_W-1:0] r_motion_threshold;
    logic [CFG_W-1:0] r_hold_time_ms;
    logic             r_out_valid;
    t_result          r_out;

    // The next result may be committed when the output register is empty or
    // is being emptied in the same cycle.
    assign out_free = !r_out_valid || i_m_axis_tready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion_threshold <= MOTION_THRESHOLD_RST;
            r_hold_time_ms     <= HOLD_TIME_MS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MOTION_THRESHOLD: r_motion_threshold <= i_cfg_wdata;
                CFG_HOLD_TIME_MS:     r_hold_time_ms     <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    mad_ctrl #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_out_free (out_free),
        .o_in_ready (o_s_axis_tready),
        .o_ctrl     (dp_ctrl)
    );

    mad_datapath #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_ctrl      (dp_ctrl),
        .i_accel_x   (i_s_axis_tdata[S-1:0]),
        .i_accel_y   (i_s_axis_tdata[2*S-1:S]),
        .i_accel_z   (i_s_axis_tdata[3*S-1:2*S]),
        .i_time_ms   (i_s_axis_tdata[3*S+TIME_FIELD_W-1:3*S]),
        .o_magnitude (magnitude),
        .o_now       (now)
    );

    mad_decide #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_decide (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_commit    (dp_ctrl.commit),
        .i_magnitude (magnitude),
        .i_now       (now),
        .i_threshold (r_motion_threshold),
        .i_hold_ms   (r_hold_time_ms),
        .o_result    (result)
    );

    // Output register: holds one finished result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (dp_ctrl.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dp_ctrl.commit) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_out.change, r_out.magnitude,
                                           r_out.moving, r_out.alert});

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("sample word accepted while the previous one is in flight");

    a_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_ctrl.commit |=> o_m_axis_tvalid)
        else $error("committed result did not reach the output");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_ctrl.commit |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("result committed over an untaken output word");
`endif

endmodule

>>> test/motion_alert_detector_test.sv
module motion_alert_detector_test;
    import mad_pkg::*;

    // The block is tested at its default widths: 16-bit axes and 32-bit time.
    localparam int SAMPLE_W   = SAMPLE_BITS_DEF;
    localparam int IN_TDATA_W = ((3 * SAMPLE_W + TIME_FIELD_W + 7) / 8) * 8;

    // The settling pause after the last result is longer than the time from
    // acceptance to result.
    localparam int SETTLE_CYCLES = SAMPLE_W + 10;
    localparam int MAX_REPORTS   = 10;

    // One accelerometer sample as the sender sees it.
    typedef struct {
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic signed [SAMPLE_W-1:0] z;
        logic [TIME_FIELD_W-1:0]    t;
    } t_sample;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_s_axis_tvalid;
    logic                    o_s_axis_tready;
    logic [IN_TDATA_W-1:0]   i_s_axis_tdata;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready;
    logic [OUT_TDATA_W-1:0]  o_m_axis_tdata;
    logic                    i_cfg_we;
    logic [CFG_ADDR_W-1:0]   i_cfg_addr;
    logic [CFG_W-1:0]        i_cfg_wdata;

    motion_alert_detector dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // Clock with a period of 12 time units.
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Copy of the detector's configuration and state, kept by the predictor.
    logic [CFG_W-1:0]        thr_reg;
    logic [CFG_W-1:0]        hold_reg;
    logic [SAMPLE_W:0]       last_mag;
    logic                    alert_now;
    logic [TIME_FIELD_W-1:0] move_start;
    logic                    move_running;
    logic [TIME_FIELD_W-1:0] rest_start;
    logic                    rest_running;

    // Results predicted for accepted sample words, oldest first.
    t_result expected_results[$];

    // Idling is switched off for the closing stretch of the run.
    bit idle_on;
    int stall_left;

    int sent_count;
    int result_count;
    int error_count;
    int setting_count;
    int alert_changes;
    logic last_alert_seen;

    // Generator state for the random traffic: a running clock in
    // milliseconds, the current burst of movement or stillness, and the
    // resting vector that still samples jitter around.
    logic [TIME_FIELD_W-1:0] now_ms;
    int  burst_left;
    bit  burst_moving;
    int  base_x;
    int  base_y;
    int  base_z;

    // Hard limit on the run. The slowest legal run (every word meeting the
    // longest sender gap, the block's own cycles and the longest receiver
    // stall) takes about a fifth of this.
    initial begin
        #5000000;
        $display("Verification failed");
        $display("Run stopped by the time limit with %0d result words outstanding.",
                 expected_results.size());
        $finish;
    end

    // Floor square root by setting root bits from the top down, keeping a bit
    // whenever the square of the trial root still fits.
    function automatic logic [SAMPLE_W:0] floor_root(input longint unsigned n);
        logic [SAMPLE_W:0] root;
        longint unsigned   trial;
        int                b;
        root = '0;
        for (b = SAMPLE_W; b >= 0; b--) begin
            trial = longint'(root) | (64'd1 << b);
            if (trial * trial <= n) begin
                root = trial[SAMPLE_W:0];
            end
        end
        return root;
    endfunction

    function automatic longint unsigned axis_abs(input logic signed [SAMPLE_W-1:0] v);
        longint s;
        s = v;
        return (s < 0) ? -s : s;
    endfunction

    // Works out the result word for one accepted sample and advances the
    // predictor's state exactly as the detector should.
    function automatic t_result predict_detector(input t_sample s);
        t_result           r;
        longint unsigned   ax;
        longint unsigned   ay;
        longint unsigned   az;
        logic [SAMPLE_W:0] mag;
        logic [SAMPLE_W:0] chg;
        logic              mv;
        logic [TIME_FIELD_W-1:0] dt;
        ax  = axis_abs(s.x);
        ay  = axis_abs(s.y);
        az  = axis_abs(s.z);
        mag = floor_root(ax * ax + ay * ay + az * az);
        chg = (mag >= last_mag) ? mag - last_mag : last_mag - mag;
        mv  = (chg > {1'b0, thr_reg});

        // Timers are started or stopped before the state is tested, so a
        // timer started by this sample has zero elapsed time.
        if (mv) begin
            if (!move_running) begin
                move_start   = s.t;
                move_running = 1'b1;
            end
            rest_running = 1'b0;
        end else begin
            if (!rest_running) begin
                rest_start   = s.t;
                rest_running = 1'b1;
            end
            move_running = 1'b0;
        end

        // Elapsed time wraps with the 32-bit timestamp.
        if (!alert_now) begin
            dt = s.t - move_start;
            if (move_running && dt > {16'd0, hold_reg}) begin
                alert_now = 1'b1;
            end
        end else begin
            dt = s.t - rest_start;
            if (rest_running && dt > {16'd0, hold_reg}) begin
                alert_now = 1'b0;
            end
        end

        last_mag    = mag;
        r.alert     = alert_now;
        r.moving    = mv;
        r.magnitude = mag[OUT_FIELD_W-1:0];
        r.change    = chg[OUT_FIELD_W-1:0];
        return r;
    endfunction

    function automatic t_sample make_sample(input int x, input int y, input int z,
                                            input logic [TIME_FIELD_W-1:0] t);
        t_sample s;
        s.x = x[SAMPLE_W-1:0];
        s.y = y[SAMPLE_W-1:0];
        s.z = z[SAMPLE_W-1:0];
        s.t = t;
        return s;
    endfunction

    function automatic int rand_axis();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // Offers one sample word and holds it until the block takes it. Valid is
    // left high afterwards unless a random gap follows, so that back-to-back
    // words see no bubble.
    task automatic send_sample(input t_sample s);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {s.t, s.z, s.y, s.x};
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        expected_results.push_back(predict_detector(s));
        sent_count++;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk) i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(0, 15)) @(negedge i_clk);
        end
    endtask

    // Stops offering words and waits until every predicted result has been
    // seen, then lets the block settle.
    task automatic wait_until_idle();
        @(negedge i_clk) i_s_axis_tvalid = 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes both registers while the block is idle.
    task automatic apply_settings(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] hold);
        wait_until_idle();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = CFG_MOTION_THRESHOLD;
        i_cfg_wdata = thr;
        @(negedge i_clk);
        i_cfg_addr  = CFG_HOLD_TIME_MS;
        i_cfg_wdata = hold;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        thr_reg  = thr;
        hold_reg = hold;
        setting_count++;
    endtask

    // Directed: the first sample after reset, with the default registers. The
    // previous magnitude starts at zero, so the first change is the whole
    // magnitude; the first timestamp is zero and must be treated as ordinary.
    task automatic test_first_sample();
        send_sample(make_sample(0, 0, 4096, 32'd0));
        send_sample(make_sample(0, 0, 4096, 32'd100));
        send_sample(make_sample(0, 0, 0, 32'd200));
        send_sample(make_sample(0, 0, 0, 32'd300));
    endtask

    // Directed: the hold time is strict in both directions. Movement lasting
    // exactly the hold time leaves the block calm; one millisecond more
    // raises the alert, and the same holds for stillness on the way back.
    task automatic test_hold_boundary();
        apply_settings(16'd10, 16'd100);
        send_sample(make_sample(0, 0, 1000, 32'd1000));
        send_sample(make_sample(0, 0, 2000, 32'd1100));
        send_sample(make_sample(0, 0, 3000, 32'd1101));
        send_sample(make_sample(0, 0, 3000, 32'd1150));
        send_sample(make_sample(0, 0, 3000, 32'd1250));
        send_sample(make_sample(0, 0, 3000, 32'd1251));
        send_sample(make_sample(0, 0, 3005, 32'd1300));
    endtask

    // Directed: movement and stillness timed across the wrap of the
    // timestamp, where the elapsed time is taken modulo 2^32.
    task automatic test_timestamp_wrap();
        send_sample(make_sample(0, 0, 100, 32'hFFFF_FFC0));
        send_sample(make_sample(0, 0, 500, 32'h0000_0030));
        send_sample(make_sample(0, 0, 500, 32'h0000_0040));
        send_sample(make_sample(0, 0, 500, 32'h0000_00B0));
    endtask

    // Directed: the largest and smallest axis values, a zero threshold and a
    // zero hold time, then both registers at their maximum.
    task automatic test_field_extremes();
        apply_settings(16'd0, 16'd0);
        send_sample(make_sample(-32768, -32768, -32768, 32'hFFFF_FFFF));
        send_sample(make_sample(32767, 32767, 32767, 32'd0));
        send_sample(make_sample(32767, 32767, 32767, 32'd0));
        send_sample(make_sample(32767, -32768, 0, 32'd1));
        send_sample(make_sample(1, -1, 1, 32'd2));
        apply_settings(16'hFFFF, 16'hFFFF);
        send_sample(make_sample(-32768, 0, 32767, 32'd3));
        send_sample(make_sample(0, 0, 0, 32'd70000));
    endtask

    // Random traffic under one setting of the registers. Most words follow a
    // plausible sensor trace: bursts of movement (large swings of the vector)
    // and of stillness (small jitter around a resting vector), with time
    // stepping on by a fraction of the hold time so that alerts come and go.
    // About one word in ten is noise with every field random.
    task automatic run_random_phase(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] hold,
                                    input int count);
        t_sample s;
        int      step_max;
        int      jit;
        int      i;
        apply_settings(thr, hold);
        step_max = int'(hold) / 4 + 2;
        jit      = (int'(thr) / 4 > 500) ? 500 : int'(thr) / 4;
        for (i = 0; i < count; i++) begin
            // Halfway through, the sender holds back until the block has
            // returned every result.
            if (i == count / 2) begin
                wait_until_idle();
            end
            if ($urandom_range(0, 9) == 0) begin
                s.x = SAMPLE_W'($urandom);
                s.y = SAMPLE_W'($urandom);
                s.z = SAMPLE_W'($urandom);
                s.t = $urandom;
            end else begin
                if (burst_left == 0) begin
                    burst_moving = 1'($urandom_range(0, 1));
                    burst_left   = $urandom_range(1, 24);
                    base_x = int'($urandom_range(0, 60000)) - 30000;
                    base_y = int'($urandom_range(0, 60000)) - 30000;
                    base_z = int'($urandom_range(0, 60000)) - 30000;
                end
                burst_left--;
                if ($urandom_range(0, 99) == 0) begin
                    now_ms = 32'hFFFF_FFFF - $urandom_range(0, 4 * step_max);
                end else begin
                    now_ms = now_ms + $urandom_range(0, step_max);
                end
                if (burst_moving) begin
                    s = make_sample(rand_axis(), rand_axis(), rand_axis(), now_ms);
                end else begin
                    s = make_sample(base_x + int'($urandom_range(0, 2 * jit)) - jit,
                                    base_y + int'($urandom_range(0, 2 * jit)) - jit,
                                    base_z + int'($urandom_range(0, 2 * jit)) - jit,
                                    now_ms);
                end
            end
            send_sample(s);
        end
    endtask

    // Random traffic over several settings, the extremes among them.
    task automatic test_random_traffic();
        run_random_phase(MOTION_THRESHOLD_RST, HOLD_TIME_MS_RST, 200);
        run_random_phase(16'd0, 16'd0, 150);
        run_random_phase(16'hFFFF, 16'hFFFF, 100);
        run_random_phase(16'd50, 16'd300, 200);
        run_random_phase(CFG_W'($urandom_range(0, 65535)),
                         CFG_W'($urandom_range(0, 65535)), 200);
        run_random_phase(CFG_W'($urandom_range(0, 2000)),
                         CFG_W'($urandom_range(0, 3000)), 200);
        run_random_phase(CFG_W'($urandom_range(0, 400)),
                         CFG_W'($urandom_range(0, 500)), 150);
    endtask

    // The closing stretch runs with no idling on either side, so the block
    // is driven at its full rate.
    task automatic test_full_rate();
        wait_until_idle();
        idle_on = 1'b0;
        run_random_phase(16'd205, 16'd1000, 200);
    endtask

    // Receiver: stalls in random bursts while idling is on.
    initial begin
        i_m_axis_tready = 1'b1;
        stall_left      = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left != 0) begin
                stall_left--;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 16);
            end
            i_m_axis_tready = (stall_left == 0);
        end
    end

    // Every result word taken from the block is compared with the oldest
    // prediction still waiting.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin : check_word
            t_result want;
            t_result got;
            got.alert     = o_m_axis_tdata[0];
            got.moving    = o_m_axis_tdata[1];
            got.magnitude = o_m_axis_tdata[2 +: OUT_FIELD_W];
            got.change    = o_m_axis_tdata[2 + OUT_FIELD_W +: OUT_FIELD_W];
            result_count++;
            if (got.alert !== last_alert_seen) begin
                alert_changes++;
            end
            last_alert_seen = got.alert;
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("Result word %0d arrived with no sample waiting for it: %h",
                             result_count, o_m_axis_tdata);
                end
            end else begin
                want = expected_results.pop_front();
                if (got.alert !== want.alert || got.moving !== want.moving ||
                        got.magnitude !== want.magnitude || got.change !== want.change) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("Result word %0d wrong: ", result_count,
                                 "expected alert %0d moving %0d mag %0d chg %0d, ",
                                 want.alert, want.moving, want.magnitude, want.change,
                                 "got alert %0d moving %0d mag %0d chg %0d",
                                 got.alert, got.moving, got.magnitude, got.change);
                    end
                end
            end
        end
    end

    initial begin
        // All inputs are known from the start, while reset is held active.
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = CFG_MOTION_THRESHOLD;
        i_cfg_wdata     = '0;
        idle_on         = 1'b1;
        sent_count      = 0;
        result_count    = 0;
        error_count     = 0;
        setting_count   = 0;
        alert_changes   = 0;
        last_alert_seen = 1'b0;
        now_ms          = $urandom;
        burst_left      = 0;
        burst_moving    = 1'b0;
        base_x          = 0;
        base_y          = 0;
        base_z          = 0;

        // The predictor starts where reset leaves the block.
        thr_reg      = MOTION_THRESHOLD_RST;
        hold_reg     = HOLD_TIME_MS_RST;
        last_mag     = '0;
        alert_now    = 1'b0;
        move_start   = '0;
        move_running = 1'b0;
        rest_start   = '0;
        rest_running = 1'b0;

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_first_sample();
        test_hold_boundary();
        test_timestamp_wrap();
        test_field_extremes();
        test_random_traffic();
        test_full_rate();

        wait_until_idle();

        $display("Sent %0d sample words under %0d register settings; %0d result words checked.",
                 sent_count, setting_count, result_count);
        $display("The alert output changed %0d times; %0d result words were wrong.",
                 alert_changes, error_count);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> motion_alert_detector.f
design/mad_pkg.sv
design/mad_ctrl.sv
design/mad_datapath.sv
design/mad_decide.sv
design/motion_alert_detector.sv
test/motion_alert_detector_test.sv
